FILE: rtl/adc_ss_pkg.sv
// ----------------------------------------------------------------------------
// adc_ss_pkg
// Shared types and constants for the ADC scan sequencer.
// ----------------------------------------------------------------------------
package adc_ss_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CHAN_W       = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = CHAN_W + 1;
  localparam int ADDR_W       = 7;
  localparam int CFGW_W       = 16;
  localparam int FLAG_W       = 6;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_CFG_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_CFG_HIGH = 3'd4;

  // Request kinds on the input stream
  localparam logic [1:0] REQ_POLL   = 2'd0;
  localparam logic [1:0] REQ_DONE   = 2'd1;
  localparam logic [1:0] REQ_ERROR  = 2'd2;
  localparam logic [1:0] REQ_STATUS = 2'd3;

  // Result actions
  localparam logic [2:0] ACT_WR_CFG  = 3'd0;
  localparam logic [2:0] ACT_WR_PTR  = 3'd1;
  localparam logic [2:0] ACT_RD2     = 3'd2;
  localparam logic [2:0] ACT_STORE   = 3'd3;
  localparam logic [2:0] ACT_STATUS  = 3'd4;

  // Bus byte constants
  localparam logic [7:0] PTR_CONFIG   = 8'h01;
  localparam logic [1:0] LEN_CONFIG   = 2'd3;
  localparam logic [1:0] LEN_POINTER  = 2'd1;

  // Error codes that set a sticky flag
  localparam logic signed [3:0] ERR_CODE_MIN = -4'sd7;
  localparam logic signed [3:0] ERR_CODE_MAX = -4'sd2;

  typedef enum logic [2:0] {
    PH_INIT        = 3'd0,
    PH_INIT_TX     = 3'd1,
    PH_READ_CFG    = 3'd2,
    PH_READ_CFG_TX = 3'd3,
    PH_REG0        = 3'd4,
    PH_READ_ADC    = 3'd5,
    PH_READ_ADC_TX = 3'd6,
    PH_NEXT_CHAN   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [3:0]  num_channels;
    logic [3:0]  slot_base;
    logic [55:0] device_addrs;
    logic [63:0] adc_cfg_low;
    logic [63:0] adc_cfg_high;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [ADDR_W-1:0] dev_addr;
    logic [23:0]       tx_bytes;
    logic [1:0]        tx_len;
    logic [3:0]        slot;
    logic [15:0]       value;
    logic [FLAG_W-1:0] error_flags;
  } result_t;

endpackage

FILE: rtl/adc_scan_sequencer_unit.sv
// ----------------------------------------------------------------------------
// adc_scan_sequencer_unit
// Round-robin I2C ADC scan sequencer driven by bus event words.
// ----------------------------------------------------------------------------
// Each event word (poll tick, transfer done, transfer error, status read) is
// captured in an input register, applied from there to the scan state
// machine once the output side has room, and any bus action or stored sample
// it causes lands in an output register. A new word is taken every clock
// cycle while the output side keeps up. The output register and input
// register together let the next word enter while a result waits to be taken.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
module adc_scan_sequencer_unit
  import adc_ss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Event stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // err_code[3:0], rx_data[19:4], zero pad
  input  logic [1:0]            s_axis_tuser,  // req_type[1:0]
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // dev_addr[6:0], tx_bytes[30:7],
                                               // tx_len[32:31], slot[36:33],
                                               // value[52:37], error_flags[58:53]
  output logic [2:0]            m_axis_tuser   // action[2:0]
);

  cfg_t              cfg;
  logic              in_valid;
  logic [1:0]        in_req;
  logic signed [3:0] in_code;
  logic [15:0]       in_rx;
  logic              out_ready;
  logic              step;
  logic              res_valid;
  result_t           res;
  result_t           held;

  adc_ss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register
  assign step          = in_valid && out_ready;
  assign s_axis_tready = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req  <= s_axis_tuser;
      in_code <= s_axis_tdata[3:0];
      in_rx   <= s_axis_tdata[19:4];
    end
  end

  adc_ss_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .req_type  (in_req),
    .err_code  (in_code),
    .rx_data   (in_rx),
    .res_valid (res_valid),
    .res       (res)
  );

  adc_ss_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step && res_valid),
    .res           (res),
    .ready         (out_ready),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .held          (held)
  );

  // Pack the result word
  assign m_axis_tuser = held.action;
  assign m_axis_tdata = {5'd0, held.error_flags, held.value, held.slot,
                         held.tx_len, held.tx_bytes, held.dev_addr};

endmodule

FILE: rtl/adc_ss_cfg.sv
// ----------------------------------------------------------------------------
// adc_ss_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module adc_ss_cfg
  import adc_ss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_channels <= 4'd1;
      cfg.slot_base    <= 4'd2;
      cfg.device_addrs <= '0;
      cfg.adc_cfg_low  <= '0;
      cfg.adc_cfg_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_CHANNELS: cfg.num_channels <= cfg_wdata[3:0];
        REG_SLOT_BASE:    cfg.slot_base    <= cfg_wdata[3:0];
        REG_DEVICE_ADDRS: cfg.device_addrs <= cfg_wdata[55:0];
        REG_ADC_CFG_LOW:  cfg.adc_cfg_low  <= cfg_wdata;
        REG_ADC_CFG_HIGH: cfg.adc_cfg_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/adc_ss_core.sv
// ----------------------------------------------------------------------------
// adc_ss_core
// Scan state machine: one request word per step, at most one result.
// ----------------------------------------------------------------------------
module adc_ss_core
  import adc_ss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              step,
  input  logic [1:0]        req_type,
  input  logic signed [3:0] err_code,
  input  logic [15:0]       rx_data,
  output logic              res_valid,
  output result_t           res
);

  phase_t             phase, phase_next;
  logic [CHAN_W-1:0]  chan_index, chan_index_next;
  logic               busy, busy_next;
  logic               err_seen, err_seen_next;
  logic [15:0]        rx_hold, rx_hold_next;
  logic [FLAG_W-1:0]  flag_bits, flag_bits_next;
  logic               status_read_seen, status_read_seen_next;

  logic [ADDR_W-1:0]  addr_arr [MAX_CHANNELS];
  logic [CFGW_W-1:0]  cfgw_arr [MAX_CHANNELS];
  logic [ADDR_W-1:0]  ch_addr;
  logic [CFGW_W-1:0]  ch_cfgw;
  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W-1:0]   chan_inc;
  logic [CHAN_W-1:0]  chan_adv;
  logic [2:0]         flag_idx;
  logic [FLAG_W-1:0]  flags_base;

  // Per-channel address and config word lanes
  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      addr_arr[i] = cfg.device_addrs[ADDR_W*i +: ADDR_W];
      if (i < 4) begin
        cfgw_arr[i] = cfg.adc_cfg_low[CFGW_W*(i%4) +: CFGW_W];
      end else begin
        cfgw_arr[i] = cfg.adc_cfg_high[CFGW_W*(i%4) +: CFGW_W];
      end
    end
  end

  assign ch_addr = addr_arr[chan_index];
  assign ch_cfgw = cfgw_arr[chan_index];

  // Channel advance with the count clamped to 1..MAX_CHANNELS
  always_comb begin
    if (cfg.num_channels == 4'd0) begin
      n_eff = CNT_W'(1);
    end else if (cfg.num_channels > 4'(MAX_CHANNELS)) begin
      n_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = cfg.num_channels[CNT_W-1:0];
    end
    chan_inc = {1'b0, chan_index} + CNT_W'(1);
    chan_adv = (chan_inc >= n_eff) ? '0 : chan_inc[CHAN_W-1:0];
  end

  // Sticky flag bit position for codes -7..-2
  assign flag_idx = 3'(err_code - ERR_CODE_MIN);

  // Next state and result
  always_comb begin
    phase_next            = phase;
    chan_index_next       = chan_index;
    busy_next             = busy;
    err_seen_next         = err_seen;
    rx_hold_next          = rx_hold;
    flag_bits_next        = flag_bits;
    status_read_seen_next = status_read_seen;
    flags_base            = flag_bits;
    res_valid             = 1'b0;
    res                   = '0;
    res.error_flags       = flag_bits;

    case (req_type)
      REQ_DONE: begin
        if (busy) begin
          busy_next    = 1'b0;
          rx_hold_next = rx_data;
        end
      end
      REQ_ERROR: begin
        busy_next     = 1'b0;
        err_seen_next = 1'b1;
        if (status_read_seen) begin
          flags_base            = '0;
          status_read_seen_next = 1'b0;
        end
        flag_bits_next = flags_base;
        if ((err_code >= ERR_CODE_MIN) && (err_code <= ERR_CODE_MAX)) begin
          flag_bits_next = flags_base | (FLAG_W'(1) << flag_idx);
        end
      end
      REQ_STATUS: begin
        status_read_seen_next = 1'b1;
        res_valid             = 1'b1;
        res.action            = ACT_STATUS;
      end
      default: begin
        case (phase)
          PH_INIT: begin
            busy_next     = 1'b1;
            err_seen_next = 1'b0;
            phase_next    = PH_INIT_TX;
            res_valid     = 1'b1;
            res.action    = ACT_WR_CFG;
            res.dev_addr  = ch_addr;
            res.tx_bytes  = {PTR_CONFIG, ch_cfgw};
            res.tx_len    = LEN_CONFIG;
          end
          PH_INIT_TX: begin
            if (!busy) begin
              phase_next = err_seen ? PH_NEXT_CHAN : PH_READ_CFG;
            end
          end
          PH_READ_CFG, PH_READ_ADC: begin
            busy_next     = 1'b1;
            err_seen_next = 1'b0;
            phase_next    = (phase == PH_READ_CFG) ? PH_READ_CFG_TX : PH_READ_ADC_TX;
            res_valid     = 1'b1;
            res.action    = ACT_RD2;
            res.dev_addr  = ch_addr;
          end
          PH_READ_CFG_TX: begin
            if (!busy) begin
              if (err_seen) begin
                phase_next = PH_NEXT_CHAN;
              end else if (rx_hold[15]) begin
                phase_next = PH_REG0;
              end else begin
                phase_next = PH_READ_CFG;
              end
            end
          end
          PH_REG0: begin
            busy_next     = 1'b1;
            err_seen_next = 1'b0;
            phase_next    = PH_READ_ADC;
            res_valid     = 1'b1;
            res.action    = ACT_WR_PTR;
            res.dev_addr  = ch_addr;
            res.tx_len    = LEN_POINTER;
          end
          PH_READ_ADC_TX: begin
            if (!busy) begin
              if (err_seen) begin
                phase_next = PH_NEXT_CHAN;
              end else begin
                res_valid       = 1'b1;
                res.action      = ACT_STORE;
                res.slot        = cfg.slot_base + 4'(chan_index);
                res.value       = rx_hold;
                chan_index_next = chan_adv;
                phase_next      = PH_INIT;
              end
            end
          end
          default: begin
            chan_index_next = chan_adv;
            phase_next      = PH_INIT;
          end
        endcase
      end
    endcase
  end

  // State registers, updated once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_INIT;
      chan_index       <= '0;
      busy             <= 1'b0;
      err_seen         <= 1'b0;
      rx_hold          <= '0;
      flag_bits        <= '0;
      status_read_seen <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      chan_index       <= chan_index_next;
      busy             <= busy_next;
      err_seen         <= err_seen_next;
      rx_hold          <= rx_hold_next;
      flag_bits        <= flag_bits_next;
      status_read_seen <= status_read_seen_next;
    end
  end

endmodule

FILE: rtl/adc_ss_out.sv
// ----------------------------------------------------------------------------
// adc_ss_out
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module adc_ss_out
  import adc_ss_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    ready,
  input  logic    m_axis_tready,
  output logic    m_axis_tvalid,
  output result_t held
);

  // Room when empty or when the held word leaves this cycle
  assign ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ready) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      held <= res;
    end
  end

endmodule

FILE: tb/tb_adc_scan_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_adc_scan_sequencer_unit
// Self-checking testbench for the round-robin ADC scan sequencer.
// ----------------------------------------------------------------------------
// Event words go in on the slave stream and bus actions come back on the
// master stream. A scoreboard inside the testbench tracks the scan state: phase,
// channel, busy, sticky error flags. It uses that state to build the action
// each accepted word should cause. Results are checked field by field, in
// order. The stimulus starts with a short directed table. Random words follow
// and mostly play the part of a well-behaved I2C bus. Between runs the
// registers are rewritten, the idle pattern changes, and at one point the
// result side is held off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_adc_scan_sequencer_unit;
  import adc_ss_pkg::*;

  localparam int WD_LIMIT    = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 4;

  localparam logic signed [3:0] ERR_OK        = 4'sd0;
  localparam logic signed [3:0] ERR_UNFLAGGED = -4'sd1;

  typedef struct {
    logic [1:0]        req;
    logic signed [3:0] code;
    logic [15:0]       rx;
    bit                typed;
    result_t           want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // err_code[3:0], rx_data[19:4], zero pad
  logic [1:0]            s_axis_tuser = '0;   // req_type[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // dev_addr[6:0], tx_bytes[30:7],
                                              // tx_len[32:31], slot[36:33],
                                              // value[52:37], error_flags[58:53]
  logic [2:0]            m_axis_tuser;        // action[2:0]

  // Word on offer: typed expectation travels with it
  bit      item_typed = 1'b0;
  result_t item_want = '0;

  // Idle pattern and hold-off control
  int send_gap_pct = 17;
  int recv_gap_pct = 74;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int      err_count = 0;
  int      quiet_cycles = 0;
  result_t due_results[$];
  stim_row_t dir_rows[$];

  // Scoreboard copy of the scan state and registers
  cfg_t        shadow_cfg;
  phase_t      scan_phase;
  logic [2:0]  scan_chan;
  bit          bus_busy;
  bit          xfer_failed;
  logic [15:0] rx_hold;
  logic [5:0]  sticky_flags;
  bit          status_read;

  adc_scan_sequencer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t mk_res(logic [2:0] act, logic [6:0] addr, logic [23:0] bytes,
                                     logic [1:0] len, logic [3:0] slot, logic [15:0] val,
                                     logic [5:0] flags);
    mk_res = {act, addr, bytes, len, slot, val, flags};
  endfunction

  // Step the scan state by one event word; res is valid when has is set
  task automatic advance_scan(input logic [1:0] req, input logic signed [3:0] code,
                              input logic [15:0] rx, output bit has, output result_t res);
    logic [2:0]  ch;
    logic [2:0]  nxt;
    logic [6:0]  addr;
    logic [15:0] cfg_word;
    logic [3:0]  slot_n;
    int          n;
    has = 1'b0;
    res = '0;
    ch = scan_chan;
    addr = shadow_cfg.device_addrs[ch*7 +: 7];
    cfg_word = ch[2] ? shadow_cfg.adc_cfg_high[ch[1:0]*16 +: 16]
                     : shadow_cfg.adc_cfg_low[ch[1:0]*16 +: 16];
    slot_n = shadow_cfg.slot_base + {1'b0, ch};
    // clamp channel count, then wrap
    n = shadow_cfg.num_channels;
    if (n == 0) n = 1;
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    nxt = (int'(ch) + 1 >= n) ? 3'd0 : ch + 3'd1;

    case (req)
      REQ_DONE: begin
        if (bus_busy) begin
          bus_busy = 1'b0;
          rx_hold = rx;
        end
      end
      REQ_ERROR: begin
        bus_busy = 1'b0;
        xfer_failed = 1'b1;
        if (status_read) begin
          sticky_flags = '0;
          status_read = 1'b0;
        end
        if (code >= ERR_CODE_MIN && code <= ERR_CODE_MAX)
          sticky_flags[int'(code) + 7] = 1'b1;
      end
      REQ_STATUS: begin
        status_read = 1'b1;
        has = 1'b1;
        res = mk_res(ACT_STATUS, '0, '0, '0, '0, '0, sticky_flags);
      end
      default: begin
        case (scan_phase)
          PH_INIT: begin
            bus_busy = 1'b1;
            xfer_failed = 1'b0;
            scan_phase = PH_INIT_TX;
            has = 1'b1;
            res = mk_res(ACT_WR_CFG, addr, {PTR_CONFIG, cfg_word}, LEN_CONFIG, '0, '0,
                         sticky_flags);
          end
          PH_INIT_TX: begin
            if (!bus_busy) scan_phase = xfer_failed ? PH_NEXT_CHAN : PH_READ_CFG;
          end
          PH_READ_CFG: begin
            bus_busy = 1'b1;
            xfer_failed = 1'b0;
            scan_phase = PH_READ_CFG_TX;
            has = 1'b1;
            res = mk_res(ACT_RD2, addr, '0, '0, '0, '0, sticky_flags);
          end
          PH_READ_CFG_TX: begin
            // conversion done when bit 15 of the config read-back is set
            if (!bus_busy) begin
              if (xfer_failed) scan_phase = PH_NEXT_CHAN;
              else if (rx_hold[15]) scan_phase = PH_REG0;
              else scan_phase = PH_READ_CFG;
            end
          end
          PH_REG0: begin
            bus_busy = 1'b1;
            xfer_failed = 1'b0;
            scan_phase = PH_READ_ADC;
            has = 1'b1;
            res = mk_res(ACT_WR_PTR, addr, '0, LEN_POINTER, '0, '0, sticky_flags);
          end
          PH_READ_ADC: begin
            bus_busy = 1'b1;
            xfer_failed = 1'b0;
            scan_phase = PH_READ_ADC_TX;
            has = 1'b1;
            res = mk_res(ACT_RD2, addr, '0, '0, '0, '0, sticky_flags);
          end
          PH_READ_ADC_TX: begin
            if (!bus_busy) begin
              if (xfer_failed) begin
                scan_phase = PH_NEXT_CHAN;
              end else begin
                has = 1'b1;
                res = mk_res(ACT_STORE, '0, '0, '0, slot_n, rx_hold, sticky_flags);
                scan_chan = nxt;
                scan_phase = PH_INIT;
              end
            end
          end
          default: begin
            scan_chan = nxt;
            scan_phase = PH_INIT;
          end
        endcase
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      err_count++;
    end
  endtask

  // Scoreboard: predict on input words, check on output words
  always @(posedge clk) begin : scoreboard
    bit      has;
    result_t res;
    result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_scan(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[19:4], has, res);
        if (item_typed) due_results.push_back(item_want);
        else if (has) due_results.push_back(res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none got action %0d data %h",
                   $time, m_axis_tuser, m_axis_tdata);
          err_count++;
        end else begin
          want = due_results.pop_front();
          check_field("action", want.action, m_axis_tuser);
          check_field("dev_addr", want.dev_addr, m_axis_tdata[6:0]);
          check_field("tx_bytes", want.tx_bytes, m_axis_tdata[30:7]);
          check_field("tx_len", want.tx_len, m_axis_tdata[32:31]);
          check_field("slot", want.slot, m_axis_tdata[36:33]);
          check_field("value", want.value, m_axis_tdata[52:37]);
          check_field("error_flags", want.error_flags, m_axis_tdata[58:53]);
        end
      end
    end
  end

  // Watchdog: cycles with no word moving and no register write
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WD_LIMIT) begin
          $display("%0t: timeout, %0d results still due", $time, due_results.size());
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Offer one word at a negedge, return at the negedge after it is taken
  task automatic send_item(input logic [1:0] req, input logic signed [3:0] code,
                           input logic [15:0] rx, input bit typed, input result_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, rx, code};
    s_axis_tuser <= req;
    item_typed <= typed;
    item_want <= want;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_row(input logic [1:0] req, input logic signed [3:0] code,
                         input logic [15:0] rx, input bit typed, input result_t want);
    stim_row_t row;
    row.req = req;
    row.code = code;
    row.rx = rx;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Mostly a well-behaved bus: polls while idle, done or error while busy
  task automatic run_random(input int count);
    logic [1:0]        req;
    logic signed [3:0] code;
    logic [15:0]       rx;
    int                pick;
    repeat (count) begin
      pick = $urandom_range(99);
      code = 4'(16 - $urandom_range(7));
      rx = 16'($urandom);
      if (pick < 8) begin
        req = 2'($urandom_range(3));
      end else if (pick < 14) begin
        req = REQ_STATUS;
        code = ERR_OK;
      end else if (bus_busy) begin
        req = ($urandom_range(99) < 85) ? REQ_DONE : REQ_ERROR;
        if (req == REQ_DONE) code = ERR_OK;
      end else begin
        req = REQ_POLL;
        code = ERR_OK;
      end
      send_item(req, code, rx, 1'b0, '0);
    end
  endtask

  // Drop valid and let every due result and in-flight word clear
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_NUM_CHANNELS: shadow_cfg.num_channels = data[3:0];
      REG_SLOT_BASE:    shadow_cfg.slot_base = data[3:0];
      REG_DEVICE_ADDRS: shadow_cfg.device_addrs = data[55:0];
      REG_ADC_CFG_LOW:  shadow_cfg.adc_cfg_low = data;
      REG_ADC_CFG_HIGH: shadow_cfg.adc_cfg_high = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [3:0] n, input logic [3:0] base, input logic [55:0] addrs,
                           input logic [63:0] lo, input logic [63:0] hi);
    write_reg(REG_NUM_CHANNELS, 64'(n));
    write_reg(REG_SLOT_BASE, 64'(base));
    write_reg(REG_DEVICE_ADDRS, 64'(addrs));
    write_reg(REG_ADC_CFG_LOW, lo);
    write_reg(REG_ADC_CFG_HIGH, hi);
    cfg_we <= 1'b0;
  endtask

  initial begin
    shadow_cfg.num_channels = 4'd1;
    shadow_cfg.slot_base = 4'd2;
    shadow_cfg.device_addrs = '0;
    shadow_cfg.adc_cfg_low = '0;
    shadow_cfg.adc_cfg_high = '0;
    scan_phase = PH_INIT;
    scan_chan = '0;
    bus_busy = 1'b0;
    xfer_failed = 1'b0;
    rx_hold = '0;
    sticky_flags = '0;
    status_read = 1'b0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed walk through one full channel scan on reset settings
    add_row(REQ_STATUS, ERR_OK, 16'h0000, 1'b1,
            mk_res(ACT_STATUS, '0, '0, '0, '0, '0, '0));
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b1,
            mk_res(ACT_WR_CFG, '0, {PTR_CONFIG, 16'h0000}, LEN_CONFIG, '0, '0, '0));
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b0, '0);        // still busy
    add_row(REQ_DONE, ERR_OK, 16'h1234, 1'b0, '0);
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b0, '0);
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b1,
            mk_res(ACT_RD2, '0, '0, '0, '0, '0, '0));
    add_row(REQ_DONE, ERR_OK, 16'h7FFF, 1'b0, '0);        // not done yet
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b0, '0);
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b0, '0);        // read again
    add_row(REQ_DONE, ERR_OK, 16'h8000, 1'b0, '0);
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b0, '0);
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b1,
            mk_res(ACT_WR_PTR, '0, '0, LEN_POINTER, '0, '0, '0));
    add_row(REQ_DONE, ERR_OK, 16'h0000, 1'b0, '0);
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b0, '0);
    add_row(REQ_DONE, ERR_OK, 16'hFFFF, 1'b0, '0);
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b1,
            mk_res(ACT_STORE, '0, '0, '0, 4'd2, 16'hFFFF, '0));
    add_row(REQ_DONE, ERR_OK, 16'hAAAA, 1'b0, '0);        // ignored, not busy
    add_row(REQ_ERROR, ERR_CODE_MIN, 16'h0000, 1'b0, '0); // error with no transfer
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b0, '0);
    add_row(REQ_ERROR, ERR_CODE_MAX, 16'h0000, 1'b0, '0); // config write fails
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b0, '0);
    add_row(REQ_POLL, ERR_OK, 16'h0000, 1'b0, '0);        // skip to next channel
    add_row(REQ_STATUS, ERR_OK, 16'h0000, 1'b1,
            mk_res(ACT_STATUS, '0, '0, '0, '0, '0, 6'h21));
    add_row(REQ_ERROR, ERR_OK, 16'h0000, 1'b0, '0);       // clears flags after status
    add_row(REQ_ERROR, ERR_UNFLAGGED, 16'h0000, 1'b0, '0);
    add_row(REQ_STATUS, ERR_OK, 16'h0000, 1'b1,
            mk_res(ACT_STATUS, '0, '0, '0, '0, '0, '0));
    foreach (dir_rows[i])
      send_item(dir_rows[i].req, dir_rows[i].code, dir_rows[i].rx, dir_rows[i].typed,
                dir_rows[i].want);

    // Random scans under several register settings
    settle();
    configure(4'd3, 4'd14, 56'({$urandom, $urandom}), {$urandom, $urandom},
              {$urandom, $urandom});
    run_random(330);

    send_gap_pct = 74;
    recv_gap_pct = 17;
    settle();
    configure(4'd15, 4'd15, '1, '1, '0);                  // count above max acts as 8
    run_random(330);

    settle();
    configure(4'd0, 4'd0, '0, {$urandom, $urandom},
              {$urandom, $urandom});                      // zero acts as 1, stale channel
    run_random(200);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    settle();
    configure(4'd8, 4'($urandom), 56'({$urandom, $urandom}), {$urandom, $urandom}, '1);
    @(posedge clk);
    hold_reqs++;                                          // long result-side stall
    @(negedge clk);
    run_random(330);

    settle();
    configure(4'd5, 4'($urandom), 56'({$urandom, $urandom}), {$urandom, $urandom},
              {$urandom, $urandom});
    run_random(530);

    settle();
    if (err_count == 0 && due_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
